>>> src/fcsd_pkg.sv
// shared types and constants for the fan curve controller with slow-down delay
package fcsd_pkg;

  localparam int TEMP_W  = 10;
  localparam int SPEED_W = 8;
  localparam int COEF_W  = 32;
  localparam int TSQ_W   = 19;
  localparam int SQ_W    = 52;
  localparam int LIN_W   = 42;
  localparam int SUM_W   = 54;
  localparam int IDX_W   = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MIN_TEMP       = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_TEMP       = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_SPEED      = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED      = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_SQUARE    = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_LINEAR    = 3'd5;
  localparam logic [IDX_W-1:0] REG_COEF_OFFSET    = 3'd6;
  localparam logic [IDX_W-1:0] REG_SLOWDOWN_LIMIT = 3'd7;

  // register reset values
  localparam logic signed [TEMP_W-1:0] RST_MIN_TEMP = 10'sd32;
  localparam logic signed [TEMP_W-1:0] RST_MAX_TEMP = 10'sd64;
  localparam logic [SPEED_W-1:0] RST_MIN_SPEED      = 8'd20;
  localparam logic [SPEED_W-1:0] RST_MAX_SPEED      = 8'd255;
  localparam logic [SPEED_W-1:0] RST_SLOWDOWN_LIMIT = 8'd8;
  localparam logic [SPEED_W-1:0] SPEED_FULL         = 8'd255;

  typedef enum logic {
    CLS_FIXED,
    CLS_CURVE
  } item_class_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_SAT,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    item_class_t              cls;
    logic [SPEED_W-1:0]       target;
    logic signed [TEMP_W-1:0] temp;
    logic [TSQ_W-1:0]         tsq;
    logic [SPEED_W-1:0]       present;
  } item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic [SPEED_W-1:0]       speed_lo;
    logic [SPEED_W-1:0]       speed_hi;
  } front_cfg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_square;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_offset;
    logic [SPEED_W-1:0]       slowdown_limit;
  } back_cfg_t;

endpackage

>>> src/fcsd_ifs.sv
// sample and result channel interfaces
interface fcsd_in_if import fcsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic [SPEED_W-1:0]       present_speed;

  modport source (output valid, temperature, present_speed, input ready);
  modport sink (input valid, temperature, present_speed, output ready);
endinterface

interface fcsd_out_if import fcsd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [SPEED_W-1:0] new_speed;

  modport source (output valid, write_enable, new_speed, input ready);
  modport sink (input valid, write_enable, new_speed, output ready);
endinterface

>>> src/fcsd_front.sv
// front end: takes samples, classifies them and squares the temperature
module fcsd_front import fcsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fcsd_in_if.sink    samples,
  input  front_cfg_t cfg,
  output logic       push_valid,
  input  logic       push_ready,
  output item_t      push_item
);

  logic                       f_valid;
  item_t                      f_item;
  item_t                      cls_item;
  logic signed [2*TEMP_W-1:0] sq_full;

  assign samples.ready = !f_valid || push_ready;
  assign push_valid    = f_valid;
  assign push_item     = f_item;

  always_comb begin
    sq_full          = (2*TEMP_W)'(samples.temperature) * (2*TEMP_W)'(samples.temperature);
    cls_item.temp    = samples.temperature;
    cls_item.present = samples.present_speed;
    cls_item.tsq     = sq_full[TSQ_W-1:0];
    cls_item.cls     = CLS_FIXED;
    cls_item.target  = cfg.speed_lo;
    if (cfg.speed_lo >= cfg.speed_hi) begin
      cls_item.target = cfg.speed_lo;
    end else if (samples.temperature <= cfg.min_temp) begin
      cls_item.target = cfg.speed_lo;
    end else if (samples.temperature >= cfg.max_temp) begin
      cls_item.target = cfg.speed_hi;
    end else begin
      cls_item.cls = CLS_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      f_item <= cls_item;
    end
  end

endmodule

>>> src/fcsd_queue.sv
// short queue of classified samples between front and back
module fcsd_queue import fcsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   cnt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = cnt != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = cnt != '0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/fcsd_back.sv
// back end: curve evaluation, slow-down filter and result register
module fcsd_back import fcsd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  back_cfg_t cfg,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  item_t     pop_item,
  fcsd_out_if.source results
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  bk_state_t                state;
  bk_state_t                state_next;
  item_t                    cur;
  logic signed [SQ_W-1:0]   p_sq;
  logic signed [LIN_W-1:0]  p_lin;
  logic signed [SUM_W-1:0]  acc;
  logic [SPEED_W-1:0]       target;
  logic [SPEED_W-1:0]       target_sat;
  logic [SPEED_W-1:0]       slowdown_count;
  logic [SPEED_W-1:0]       slowdown_count_next;
  logic [SPEED_W:0]         count_inc;
  logic                     we_next;
  logic                     o_valid;
  logic                     o_we;
  logic [SPEED_W-1:0]       o_speed;
  logic                     out_load;
  logic signed [TSQ_W:0]    tsq_s;

  assign results.valid        = o_valid;
  assign results.write_enable = o_we;
  assign results.new_speed    = o_speed;
  assign tsq_s                = signed'({1'b0, cur.tsq});

  // state sequencing
  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    out_load   = 1'b0;
    case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = (pop_item.cls == CLS_CURVE) ? BK_MUL : BK_DONE;
        end
      end
      BK_MUL:  state_next = BK_SUM;
      BK_SUM:  state_next = BK_SAT;
      BK_SAT:  state_next = BK_DONE;
      BK_DONE: begin
        if (!o_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // round half up result saturated to the pwm range
  always_comb begin
    if (acc[SUM_W-1]) begin
      target_sat = '0;
    end else if (|acc[SUM_W-2:FRAC_BITS+SPEED_W]) begin
      target_sat = SPEED_FULL;
    end else begin
      target_sat = acc[FRAC_BITS+SPEED_W-1:FRAC_BITS];
    end
  end

  // slow-down filter
  always_comb begin
    count_inc           = {1'b0, slowdown_count} + 1'b1;
    we_next             = 1'b0;
    slowdown_count_next = '0;
    if (target < cur.present) begin
      if (count_inc > {1'b0, cfg.slowdown_limit}) begin
        we_next = 1'b1;
      end else begin
        slowdown_count_next = count_inc[SPEED_W-1:0];
      end
    end else if (target > cur.present) begin
      we_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_IDLE;
      o_valid        <= 1'b0;
      slowdown_count <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        o_valid        <= 1'b1;
        slowdown_count <= slowdown_count_next;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && pop_valid) begin
      cur    <= pop_item;
      target <= pop_item.target;
    end
    if (state == BK_MUL) begin
      p_sq  <= SQ_W'(cfg.coef_square) * SQ_W'(tsq_s);
      p_lin <= LIN_W'(cfg.coef_linear) * LIN_W'(cur.temp);
    end
    if (state == BK_SUM) begin
      acc <= SUM_W'(p_sq) + SUM_W'(p_lin) + SUM_W'(cfg.coef_offset) + HALF;
    end
    if (state == BK_SAT) begin
      target <= target_sat;
    end
    if (out_load) begin
      o_we    <= we_next;
      o_speed <= target;
    end
  end

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> results.valid)
    else $error("result register not valid after load");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (pop_ready && pop_valid) |-> state == BK_IDLE)
    else $error("queue popped while busy");

  a_mul_seq: assert property (@(posedge clk) disable iff (rst)
    state == BK_MUL |=> state == BK_SUM)
    else $error("curve sequence broken");

  a_slow_count: assert property (@(posedge clk) disable iff (rst)
    (out_load && target < cur.present && !we_next) |=> slowdown_count != '0)
    else $error("held slow-down sample not counted");
`endif

endmodule

>>> src/fan_curve_with_slowdown_delay.sv
// top level: fan curve controller with slow-down delay
// path: front register, queue, back end sequencer, result register; a sample on the curve
//   also passes the multiply, sum, saturate steps in the back end
// pacing: the back end sequencer takes a new sample only after the last one has reached the
//   result register; the 2-entry queue absorbs short bursts
// reset: rst is synchronous; it loads register defaults, clears slow-down count and queue
module fan_curve_with_slowdown_delay import fcsd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  fcsd_in_if.sink           samples,
  fcsd_out_if.source        results,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  // configuration registers
  front_cfg_t fcfg;
  back_cfg_t  bcfg;

  // front to queue transfer
  logic  push_valid;
  logic  push_ready;
  item_t push_item;

  // queue to back transfer
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // register writes; an index with no register behind it does nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      fcfg.min_temp       <= RST_MIN_TEMP;
      fcfg.max_temp       <= RST_MAX_TEMP;
      fcfg.speed_lo       <= RST_MIN_SPEED;
      fcfg.speed_hi       <= RST_MAX_SPEED;
      bcfg.coef_square    <= '0;
      bcfg.coef_linear    <= '0;
      bcfg.coef_offset    <= '0;
      bcfg.slowdown_limit <= RST_SLOWDOWN_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_TEMP:       fcfg.min_temp       <= cfg_data[TEMP_W-1:0];
        REG_MAX_TEMP:       fcfg.max_temp       <= cfg_data[TEMP_W-1:0];
        REG_MIN_SPEED:      fcfg.speed_lo       <= cfg_data[SPEED_W-1:0];
        REG_MAX_SPEED:      fcfg.speed_hi       <= cfg_data[SPEED_W-1:0];
        REG_COEF_SQUARE:    bcfg.coef_square    <= cfg_data;
        REG_COEF_LINEAR:    bcfg.coef_linear    <= cfg_data;
        REG_COEF_OFFSET:    bcfg.coef_offset    <= cfg_data;
        REG_SLOWDOWN_LIMIT: bcfg.slowdown_limit <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // front: classify against the temperature window, square the temperature
  fcsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .cfg        (fcfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples the front from the multi-cycle back end
  fcsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // back: quadratic curve, rounding, saturation and the slow-down filter
  fcsd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (bcfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .results   (results)
  );

endmodule

>>> tb/fan_curve_with_slowdown_delay_tb.sv
// testbench for the fan curve controller: directed and random samples checked against a predictor
`timescale 1ns / 1ps

module fan_curve_with_slowdown_delay_tb import fcsd_pkg::*; ();

  localparam int FRAC_BITS   = 16;
  localparam int QUIET_LIMIT = 3000;  // cycles without any transfer before giving up
  localparam int IDLE_TAIL   = 12;    // settle time after the last result
  localparam int NUM_PHASES  = 7;

  // one fan command as the block reports it
  typedef struct packed {
    logic               write_enable;
    logic [SPEED_W-1:0] new_speed;
  } fan_cmd_t;

  // predicts the fan command for every accepted sample and checks results in order
  class speed_scoreboard #(int FRAC = 16);
    logic signed [TEMP_W-1:0] min_temp       = RST_MIN_TEMP;
    logic signed [TEMP_W-1:0] max_temp       = RST_MAX_TEMP;
    logic [SPEED_W-1:0]       speed_lo       = RST_MIN_SPEED;
    logic [SPEED_W-1:0]       speed_hi       = RST_MAX_SPEED;
    logic signed [COEF_W-1:0] coef_square    = '0;
    logic signed [COEF_W-1:0] coef_linear    = '0;
    logic signed [COEF_W-1:0] coef_offset    = '0;
    logic [SPEED_W-1:0]       slowdown_limit = RST_SLOWDOWN_LIMIT;
    logic [SPEED_W-1:0]       slowdown_cnt   = '0;

    fan_cmd_t expected_cmds[$];
    int errors       = 0;
    int samples_seen = 0;
    int cmds_checked = 0;
    int writes_seen  = 0;

    function void set_reg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        REG_MIN_TEMP:       min_temp       = data[TEMP_W-1:0];
        REG_MAX_TEMP:       max_temp       = data[TEMP_W-1:0];
        REG_MIN_SPEED:      speed_lo       = data[SPEED_W-1:0];
        REG_MAX_SPEED:      speed_hi       = data[SPEED_W-1:0];
        REG_COEF_SQUARE:    coef_square    = data;
        REG_COEF_LINEAR:    coef_linear    = data;
        REG_COEF_OFFSET:    coef_offset    = data;
        REG_SLOWDOWN_LIMIT: slowdown_limit = data[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [TEMP_W-1:0] t, logic [SPEED_W-1:0] present);
      longint   tl;
      longint   acc;
      fan_cmd_t cmd;
      logic [SPEED_W:0] next_cnt;
      tl = t;
      cmd.write_enable = 1'b0;
      if (speed_lo >= speed_hi) begin
        cmd.new_speed = speed_lo;
      end else if (t <= min_temp) begin
        cmd.new_speed = speed_lo;
      end else if (t >= max_temp) begin
        cmd.new_speed = speed_hi;
      end else begin
        // exact sum, then round half up and saturate to the pwm range
        acc = longint'(coef_square) * tl * tl + longint'(coef_linear) * tl
              + longint'(coef_offset) + (longint'(1) <<< (FRAC - 1));
        if (acc < 0) cmd.new_speed = '0;
        else if ((acc >>> FRAC) > 255) cmd.new_speed = SPEED_FULL;
        else cmd.new_speed = acc[FRAC +: SPEED_W];
      end
      if (cmd.new_speed < present) begin
        next_cnt = {1'b0, slowdown_cnt} + 1'b1;
        if (next_cnt > {1'b0, slowdown_limit}) begin
          slowdown_cnt = '0;
          cmd.write_enable = 1'b1;
        end else begin
          slowdown_cnt = next_cnt[SPEED_W-1:0];
        end
      end else begin
        if (cmd.new_speed > present) cmd.write_enable = 1'b1;
        slowdown_cnt = '0;
      end
      samples_seen++;
      expected_cmds.push_back(cmd);
    endfunction

    function void check_result(logic we, logic [SPEED_W-1:0] speed);
      fan_cmd_t want;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected command: we=%0b speed=%0d with no sample pending", we, speed);
        return;
      end
      want = expected_cmds.pop_front();
      cmds_checked++;
      if (we) writes_seen++;
      if (we !== want.write_enable || speed !== want.new_speed) begin
        errors++;
        if (errors <= 10)
          $display("command %0d mismatch: expected we=%0b speed=%0d, got we=%0b speed=%0d",
                   cmds_checked, want.write_enable, want.new_speed, we, speed);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [COEF_W-1:0]  cfg_data;

  fcsd_in_if  samples ();
  fcsd_out_if results ();

  fan_curve_with_slowdown_delay #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  speed_scoreboard #(FRAC_BITS) sb;

  // register image written by write_setting, indexed by register code
  logic [COEF_W-1:0] setting [8];
  int cur_lo, cur_hi, cur_min_temp, cur_limit;
  int burst_left = 0;
  int settings_applied = 0;
  int quiet_cycles = 0;

  // transfer monitors: sampled at the edge, before any nonblocking update lands
  always @(posedge clk) begin
    if (!rst && samples.valid && samples.ready)
      sb.note_sample(samples.temperature, samples.present_speed);
    if (!rst && results.valid && results.ready)
      sb.check_result(results.write_enable, results.new_speed);
  end

  // watchdog: too long with no transfer on either side ends the run
  always @(posedge clk) begin
    if ((samples.valid && samples.ready) || (results.valid && results.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver backpressure: one of four modes, picked anew at random
  initial begin
    int rx_mode;
    int rx_cnt;
    rx_mode = 0;
    rx_cnt  = 50;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_cnt == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_cnt  = $urandom_range(20, 120);
      end else begin
        rx_cnt--;
      end
      case (rx_mode)
        0: results.ready <= 1'b1;                       // no stalls at all
        1: results.ready <= 1'($urandom_range(0, 1));   // coin flip
        2: results.ready <= (rx_cnt % 5) != 0;          // short periodic stalls
        default: results.ready <= (rx_cnt % 32) < 4;    // long stalls, short windows
      endcase
    end
  end

  function automatic logic signed [TEMP_W-1:0] clamp_temp(int v);
    if (v < -512) return -10'sd512;
    if (v > 511) return 10'sd511;
    return v[TEMP_W-1:0];
  endfunction

  // one sample transfer; the sender works in bursts with random gaps between them
  task automatic send_sample(input logic signed [TEMP_W-1:0] t, input logic [SPEED_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        samples.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    samples.valid         <= 1'b1;
    samples.temperature   <= t;
    samples.present_speed <= p;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
  endtask

  // stop sending, let every expected command come back, then let the block settle
  task automatic wait_idle();
    samples.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // write the registers selected by mask from the register image, back to back
  task automatic write_setting(input logic [7:0] mask);
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= i[IDX_W-1:0];
        cfg_data  <= setting[i];
        @(posedge clk);
        sb.set_reg(i[IDX_W-1:0], setting[i]);
      end
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // random register setting; narrow registers carry junk in their unused upper bits
  task automatic pick_setting(input int ph);
    int lo, hi, min_t, max_t, lo_s, hi_s, lim;
    logic [COEF_W-1:0] word;
    lo = int'($urandom_range(0, 900)) - 512;
    hi = lo + int'($urandom_range(1, 110));
    if (hi > 511) hi = 511;
    cur_lo = lo;
    cur_hi = hi;
    min_t = lo;
    max_t = hi;
    // now and then an inverted temperature range
    if ($urandom_range(0, 7) == 0) begin
      min_t = hi;
      max_t = lo;
    end
    cur_min_temp = min_t;
    word = $urandom();
    word[TEMP_W-1:0] = min_t[TEMP_W-1:0];
    setting[REG_MIN_TEMP] = word;
    word = $urandom();
    word[TEMP_W-1:0] = max_t[TEMP_W-1:0];
    setting[REG_MAX_TEMP] = word;

    lo_s = $urandom_range(0, 120);
    hi_s = $urandom_range(130, 255);
    // min speed not below max speed pins the target
    if (ph < 6 && $urandom_range(0, 7) == 0) begin
      lo_s = hi_s;
      hi_s = $urandom_range(0, 255);
    end
    if (ph == 6) lo_s = $urandom_range(0, 100);
    word = $urandom();
    word[SPEED_W-1:0] = lo_s[SPEED_W-1:0];
    setting[REG_MIN_SPEED] = word;
    word = $urandom();
    word[SPEED_W-1:0] = hi_s[SPEED_W-1:0];
    setting[REG_MAX_SPEED] = word;

    if (ph >= 5) begin
      // full-width coefficients, hitting both signed extremes
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 3))
          0: word = 32'h7FFF_FFFF;
          1: word = 32'h8000_0000;
          default: word = $urandom();
        endcase
        setting[REG_COEF_SQUARE + k] = word;
      end
    end else begin
      // scaled so that a good part of the curve lands inside the pwm range
      setting[REG_COEF_SQUARE] = int'($urandom_range(0, 8192)) - 4096;
      setting[REG_COEF_LINEAR] = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      setting[REG_COEF_OFFSET] = int'($urandom_range(0, 600 << 16)) - (300 << 16);
    end

    if (ph == 5) lim = 0;
    else if (ph == 6) lim = 255;
    else lim = $urandom_range(0, 6);
    cur_limit = lim;
    word = $urandom();
    word[SPEED_W-1:0] = lim[SPEED_W-1:0];
    setting[REG_SLOWDOWN_LIMIT] = word;
  endtask

  // mostly runs of samples around one temperature with a fixed fan speed, which is
  // what walks the slow-down counter; the rest is full-range noise
  task automatic run_traffic(input int n);
    int sent, len, center, jitter;
    logic [SPEED_W-1:0]       p;
    logic signed [TEMP_W-1:0] tn;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 3) == 0) begin
        tn = 10'($urandom_range(0, 1023));
        send_sample(tn, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        len    = $urandom_range(1, (cur_limit + 3 > 12) ? 12 : cur_limit + 3);
        center = cur_lo - 6 + int'($urandom_range(0, cur_hi - cur_lo + 12));
        p      = 8'($urandom_range(0, 255));
        jitter = $urandom_range(0, 1);
        for (int k = 0; k < len; k++) begin
          if (jitter) send_sample(clamp_temp(center + int'($urandom_range(0, 2)) - 1), p);
          else send_sample(clamp_temp(center), p);
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < 8; i++) setting[i] = '0;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    samples.valid         <= 1'b0;
    samples.temperature   <= '0;
    samples.present_speed <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: clamped ends, temperature extremes, zero curve
    send_sample(10'sd32, 8'd0);
    send_sample(10'sd64, 8'd255);
    send_sample(10'sd40, 8'd100);
    send_sample(-10'sd512, 8'd255);
    send_sample(10'sd511, 8'd0);

    // real curve; offset of 100.5 so that t = 0 rounds half up to 101
    wait_idle();
    setting[REG_MIN_TEMP]       = 32'(-100);
    setting[REG_MAX_TEMP]       = 32'd100;
    setting[REG_MIN_SPEED]      = 32'd10;
    setting[REG_MAX_SPEED]      = 32'd250;
    setting[REG_COEF_SQUARE]    = 32'd655;
    setting[REG_COEF_LINEAR]    = 32'h0001_0000;
    setting[REG_COEF_OFFSET]    = (32'd100 << 16) | 32'h8000;
    setting[REG_SLOWDOWN_LIMIT] = 32'd2;
    write_setting(8'hFF);
    send_sample(10'sd0, 8'd0);
    send_sample(-10'sd100, 8'd0);
    send_sample(10'sd100, 8'd0);
    send_sample(-10'sd99, 8'd255);
    // three slow-down samples in a row; the sample before left the count at one: held, written, held
    repeat (3) send_sample(10'sd0, 8'd200);
    send_sample(10'sd0, 8'd101);   // target equals present speed
    send_sample(10'sd99, 8'd0);

    // inverted temperature range, coefficient extremes, longest slow-down limit
    wait_idle();
    setting[REG_MIN_TEMP]       = 32'd100;
    setting[REG_MAX_TEMP]       = 32'(-100);
    setting[REG_MIN_SPEED]      = 32'd0;
    setting[REG_MAX_SPEED]      = 32'd255;
    setting[REG_COEF_SQUARE]    = 32'h7FFF_FFFF;
    setting[REG_COEF_LINEAR]    = 32'h8000_0000;
    setting[REG_COEF_OFFSET]    = 32'h8000_0000;
    setting[REG_SLOWDOWN_LIMIT] = 32'd255;
    write_setting(8'hFF);
    send_sample(10'sd101, 8'd3);
    send_sample(10'sd511, 8'd255);
    repeat (3) send_sample(10'sd100, 8'd5);

    // limit lowered under a running count: the next slow-down sample writes
    wait_idle();
    setting[REG_SLOWDOWN_LIMIT] = $urandom() & 32'hFFFF_FF00;
    write_setting(8'h01 << REG_SLOWDOWN_LIMIT);
    send_sample(10'sd100, 8'd5);
    send_sample(10'sd0, 8'd0);

    // min speed above max speed pins the target to min speed
    wait_idle();
    setting[REG_MIN_SPEED] = 32'd200;
    setting[REG_MAX_SPEED] = 32'd100;
    write_setting((8'h01 << REG_MIN_SPEED) | (8'h01 << REG_MAX_SPEED));
    send_sample(10'sd0, 8'd0);
    send_sample(10'sd511, 8'd255);
    send_sample(-10'sd512, 8'd200);

    // random phases, the last two with full-width coefficients and limits 0 and 255
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      pick_setting(ph);
      write_setting(8'hFF);
      if (ph == 6) begin
        // long slow-down run at min temp with the fan flat out: a write comes once the count passes 255
        repeat (258) send_sample(clamp_temp(cur_min_temp), SPEED_FULL);
        run_traffic(40);
      end else begin
        run_traffic(75);
      end
    end

    wait_idle();
    $display("%0d samples, %0d commands checked, %0d fan writes, %0d mismatches",
             sb.samples_seen, sb.cmds_checked, sb.writes_seen, sb.errors);
    $display("%0d register settings: curve, clamped ends, inverted range,",
             settings_applied);
    $display("pinned speed, slow-down limits 0..255");
    if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/fcsd_pkg.sv
src/fcsd_ifs.sv
src/fcsd_front.sv
src/fcsd_queue.sv
src/fcsd_back.sv
src/fan_curve_with_slowdown_delay.sv
tb/fan_curve_with_slowdown_delay_tb.sv
